FILE: src/stg_pkg.sv
// stg_pkg: sizes, sequencer states and the sine lookup table of the tone generator
// the table is built at elaboration by a fixed-point taylor series
// no dependencies
`default_nettype none

package stg_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int CHANNELS    = 2;
  localparam int PHASE_BITS  = 32;
  localparam int TABLE_BITS  = 10;

  localparam int TBL_SIZE  = 1 << TABLE_BITS;
  localparam int QTR_BITS  = TABLE_BITS - 2;
  localparam int QTR_SIZE  = 1 << QTR_BITS;

  localparam int STEP_W    = 32;
  localparam int COUNT_W   = 7;
  localparam int FIELD_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [COUNT_W-1:0] MAX_RUN = COUNT_W'(64);

  localparam logic [STEP_W-1:0] PHASE_STEP_RST = 32'd19478310;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_UNSIGNED = 1'd1;

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam logic [63:0] ONE_Q62     = 64'h4000000000000000;
  localparam logic [63:0] MAXVAL      = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
  localparam logic [63:0] QTR_SIZE64  = 64'(QTR_SIZE);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t rom_t [TBL_SIZE];

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_e;

  // floor(a * b / 2^62), low 64 bits
  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = 128'(a) * 128'(b);
    return prod[125:62];
  endfunction

  // magnitude of the scaled sine for quarter-wave index j, 0 <= j <= QTR_SIZE
  function automatic logic [63:0] quarter_sine(input logic [63:0] j);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    if (j >= QTR_SIZE64) begin
      return MAXVAL;
    end
    x = (HALF_PI_Q62 / QTR_SIZE64) * j + ((HALF_PI_Q62 % QTR_SIZE64) * j) / QTR_SIZE64;
    x2 = qmul(x, x);
    sum = x;
    term = qmul(x, x2) / 64'd6;    sum = sum - term;
    term = qmul(term, x2) / 64'd20;  sum = sum + term;
    term = qmul(term, x2) / 64'd42;  sum = sum - term;
    term = qmul(term, x2) / 64'd72;  sum = sum + term;
    term = qmul(term, x2) / 64'd110; sum = sum - term;
    term = qmul(term, x2) / 64'd156; sum = sum + term;
    term = qmul(term, x2) / 64'd210; sum = sum - term;
    term = qmul(term, x2) / 64'd272; sum = sum + term;
    term = qmul(term, x2) / 64'd342; sum = sum - term;
    term = qmul(term, x2) / 64'd420; sum = sum + term;
    term = qmul(term, x2) / 64'd506; sum = sum - term;
    term = qmul(term, x2) / 64'd600; sum = sum + term;
    if (sum > ONE_Q62) begin
      sum = ONE_Q62;
    end
    return qmul(sum, MAXVAL);
  endfunction

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] quad;
    logic [63:0] j;
    logic [63:0] mag;
    for (int k = 0; k < TBL_SIZE; k++) begin
      quad = 64'(k) >> QTR_BITS;
      j    = 64'(k) & (QTR_SIZE64 - 64'd1);
      mag  = quad[0] ? quarter_sine(QTR_SIZE64 - j) : quarter_sine(j);
      mag  = quad[1] ? (64'd0 - mag) : mag;
      rom[k] = mag[SAMPLE_BITS-1:0];
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // keep the low field bits of a sample, zero-extending narrow samples
  function automatic logic [FIELD_W-1:0] to_field(input sample_t s);
    logic [63:0] wide;
    wide = 64'(s);
    return wide[FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/stg_req_if.sv
// stg_req_if: request channel of the tone generator, one item asks for a run of frames
// depends on stg_pkg
`default_nettype none

interface stg_req_if;
  import stg_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] frame_count;

  modport source (output valid, output frame_count, input ready);
  modport sink (input valid, input frame_count, output ready);
endinterface

`default_nettype wire

FILE: src/stg_frame_if.sv
// stg_frame_if: frame channel of the tone generator, one item per stereo frame
// depends on stg_pkg
`default_nettype none

interface stg_frame_if;
  import stg_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] sample_left;
  logic [FIELD_W-1:0] sample_right;
  logic               last_frame;

  modport source (output valid, output sample_left, output sample_right,
                  output last_frame, input ready);
  modport sink (input valid, input sample_left, input sample_right,
                input last_frame, output ready);
endinterface

`default_nettype wire

FILE: src/sine_tone_generator_core.sv
// sine_tone_generator_core: dds sine oscillator, phase accumulator plus sine table
// depends on stg_pkg, stg_req_if, stg_frame_if
//
//   port    dir  item                      fields
//   req_i   in   one run request           frame_count (0 ignored, above 64 taken as 64)
//   frame_o out  one frame of the run      sample_left, sample_right, last_frame
//   cfg_*   in   register write            index 0 phase_step, index 1 output_unsigned
//
// one frame leaves per cycle while the frame channel does not stall, set by
// the single phase adder and table read that serve each frame in turn
// requests are taken only between runs; a stalled frame channel holds the run
// the last frame of a run may still wait in the output register while a new request is taken
// reset clears phase, run count, output valid and restores the register defaults
`default_nettype none

module sine_tone_generator_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  stg_req_if.sink                         req_i,
  stg_frame_if.source                     frame_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [stg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [stg_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import stg_pkg::*;

  seq_state_e state_q, state_d;

  logic [STEP_W-1:0]     phase_step_q;
  logic                  unsigned_q;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [COUNT_W-1:0]    frames_left_q, frames_left_d;

  logic                  out_valid_q;
  sample_t               left_q, right_q;
  logic                  last_q;

  logic                  take_req;
  logic                  load_frame;
  logic [COUNT_W-1:0]    req_count;
  logic [TABLE_BITS-1:0] rom_addr;
  sample_t               pat;
  sample_t               pat_neg;
  logic                  frame_is_last;

  assign req_count = (req_i.frame_count > MAX_RUN) ? MAX_RUN : req_i.frame_count;
  assign rom_addr  = phase_q[PHASE_BITS-1 -: TABLE_BITS];
  assign pat       = SINE_ROM[rom_addr] ^ {unsigned_q, {(SAMPLE_BITS-1){1'b0}}};
  assign pat_neg   = (CHANNELS >= 2) ? (SAMPLE_BITS'(0) - pat) : SAMPLE_BITS'(0);
  assign frame_is_last = (frames_left_q == COUNT_W'(1));

  // sequencer outputs
  always_comb begin
    take_req   = 1'b0;
    load_frame = 1'b0;
    req_i.ready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        take_req    = req_i.valid;
      end
      ST_RUN: begin
        load_frame = !out_valid_q || frame_o.ready;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take_req && (req_count != '0)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (load_frame && frame_is_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // phase adder and run counter
  always_comb begin
    phase_d       = phase_q;
    frames_left_d = frames_left_q;
    if (take_req) begin
      frames_left_d = req_count;
    end else if (load_frame) begin
      phase_d       = phase_q + PHASE_BITS'(phase_step_q);
      frames_left_d = frames_left_q - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      phase_q       <= '0;
      frames_left_q <= '0;
      phase_step_q  <= PHASE_STEP_RST;
      unsigned_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      phase_q       <= phase_d;
      frames_left_q <= frames_left_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_PHASE_STEP:      phase_step_q <= cfg_data_i[STEP_W-1:0];
          REG_OUTPUT_UNSIGNED: unsigned_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (load_frame) begin
        out_valid_q <= 1'b1;
      end else if (frame_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (load_frame) begin
      left_q  <= pat;
      right_q <= pat_neg;
      last_q  <= frame_is_last;
    end
  end

  assign frame_o.valid        = out_valid_q;
  assign frame_o.sample_left  = to_field(left_q);
  assign frame_o.sample_right = to_field(right_q);
  assign frame_o.last_frame   = last_q;

endmodule

`default_nettype wire
